// File: design/allpass_chain_resonator_core_assert.svh
// assertion macros for the allpass chain resonator core
`ifndef ALLPASS_CHAIN_RESONATOR_CORE_ASSERT_SVH
`define ALLPASS_CHAIN_RESONATOR_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ACR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ACR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/acr_pkg.sv
// constants, register codes and coefficient rom generation for the resonator core
package acr_pkg;

  localparam int MAX_STAGES_DEF      = 16;
  localparam int MAX_DELAY_DEF       = 4096;
  localparam int DAMP_TABLE_SIZE_DEF = 64;
  localparam int COS_TABLE_SIZE_DEF  = 128;

  localparam logic [2:0] REG_FEEDBACK_GAIN    = 3'd0;
  localparam logic [2:0] REG_DAMP_INDEX_SCALE = 3'd1;
  localparam logic [2:0] REG_K_INDEX_SCALE    = 3'd2;
  localparam logic [2:0] REG_STAGES_IN_USE    = 3'd3;
  localparam logic [2:0] REG_DELAY_LENGTH     = 3'd4;

  localparam longint Q30_ONE       = 64'sd1073741824;
  localparam longint Q30_PI        = 64'sd3373259426;
  localparam longint Q30_HALF_PI   = 64'sd1686629713;
  localparam longint Q30_DAMP_SPAN = 64'sd2469606195;
  localparam longint Q22_ONE       = 64'sd4194304;

  // unsigned long division by shift and subtract, used for rom generation only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // taylor series in q30, sine terms when odd is set, cosine terms otherwise
  function automatic longint taylor_q30(input longint x, input bit odd);
    longint unsigned t;
    longint          acc;
    t   = 64'(Q30_ONE);
    acc = 0;
    for (int n = 0; n < 22; n++) begin
      if (n > 0) begin
        t = udiv64((t * 64'(x)) >> 30, 64'(n));
      end
      case (n % 4)
        0: if (!odd) acc = acc + longint'(t);
        1: if (odd) acc = acc + longint'(t);
        2: if (!odd) acc = acc - longint'(t);
        default: if (odd) acc = acc - longint'(t);
      endcase
    end
    return acc;
  endfunction

  function automatic longint sin_q30(input longint a);
    if (a <= Q30_HALF_PI) begin
      return taylor_q30(a, 1'b1);
    end
    return taylor_q30(a - Q30_HALF_PI, 1'b0);
  endfunction

  function automatic longint cos_q30(input longint a);
    if (a <= Q30_HALF_PI) begin
      return taylor_q30(a, 1'b0);
    end
    return -taylor_q30(a - Q30_HALF_PI, 1'b1);
  endfunction

  function automatic logic signed [23:0] sat24_long(input longint v);
    if (v > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -64'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  // damping entry: tan(v - pi/4) in q2.22, v given in q30
  function automatic logic signed [23:0] damp_entry(input longint v);
    longint s;
    longint c;
    longint den;
    longint num;
    longint q;
    s   = sin_q30(v);
    c   = cos_q30(v);
    den = s + c;
    if (den <= 0) begin
      return 24'sh7FFFFF;
    end
    num = (s - c) * Q22_ONE;
    if (num >= 0) begin
      q = longint'(udiv64(64'(num + (den >>> 1)), 64'(den)));
    end else begin
      q = -longint'(udiv64(64'(-num + (den >>> 1)), 64'(den)));
    end
    return sat24_long(q);
  endfunction

  // negative cosine entry in q2.22, angle given in q30
  function automatic logic signed [23:0] cos_entry(input longint a);
    longint num;
    longint q;
    num = -cos_q30(a);
    if (num >= 0) begin
      q = (num + 128) / 256;
    end else begin
      q = -((-num + 128) / 256);
    end
    return sat24_long(q);
  endfunction

endpackage

// File: design/allpass_chain_resonator_core.sv
// allpass chain resonator core: lookup, feedback delay loop and shared-multiplier stage chain
// a sample word passes lookup, feedback delay loop and stage chain in turn; the one 33x25
//   multiplier is shared by all of them
// one word is in work at a time; the next is taken once the result sits in the output register
// a clear word sweeps the delay memory, then gives a zero result
// synchronous reset runs the same sweep before the first word is taken
`include "allpass_chain_resonator_core_assert.svh"

module allpass_chain_resonator_core #(
  parameter int MAX_STAGES      = acr_pkg::MAX_STAGES_DEF,
  parameter int MAX_DELAY       = acr_pkg::MAX_DELAY_DEF,
  parameter int DAMP_TABLE_SIZE = acr_pkg::DAMP_TABLE_SIZE_DEF,
  parameter int COS_TABLE_SIZE  = acr_pkg::COS_TABLE_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // input word channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [23:0] audio_in,
  input  logic        [23:0] freq_in,
  // result word channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] out_left,
  output logic signed [23:0] out_right,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  // widths of pointers, counters and rom indexes
  localparam int PW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DW   = 2 * PW + 1;
  localparam int CW   = $clog2(PW + 1) + 1;
  localparam int SW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int DAW  = $clog2(DAMP_TABLE_SIZE);
  localparam int CAW  = $clog2(COS_TABLE_SIZE);
  localparam int ACCW = 60;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR,
    L_MUL, L_ROM, L_INT, L_SUM,
    S_KMUL, S_KSAT,
    S_PMOD, S_DRD, S_FBMUL, S_FBSUM,
    ST_A, ST_B, ST_C, ST_D, ST_E, ST_F, ST_G,
    S_WB, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic signed [18:0] feedback_gain;
  logic        [31:0] damp_index_scale;
  logic        [31:0] k_index_scale;
  logic        [4:0]  stages_in_use;
  logic        [12:0] delay_length;

  // word being worked on
  logic signed [23:0] audio_q;
  logic        [23:0] freq_q;
  logic               lk;          // 0 damping lookup, 1 cosine lookup
  logic signed [23:0] rom_base_q;
  logic signed [24:0] rom_diff_q;
  logic        [15:0] rom_frac_q;
  logic signed [23:0] c_coef;
  logic signed [23:0] k_raw;
  logic signed [23:0] k_coef;
  logic signed [31:0] x;
  logic signed [31:0] w0r;
  logic signed [ACCW-1:0] acc;
  logic signed [23:0] left_q;
  logic signed [23:0] right_q;
  logic        [SW-1:0] stg;

  // stage state, one pair per stage
  logic signed [31:0] w1 [MAX_STAGES];
  logic signed [31:0] w2 [MAX_STAGES];

  // delay loop
  logic [PW-1:0] pointer;
  logic [PW:0]   rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] bcnt;
  logic [PW-1:0] clr_addr;
  logic          clr_item;
  logic signed [23:0] delay_mem [MAX_DELAY];
  logic signed [23:0] dl_q;

  // shared multiplier, product registered every cycle
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;

  // coefficient roms, values fixed at elaboration
  logic signed [23:0] damp_rom [DAMP_TABLE_SIZE];
  logic signed [23:0] cos_rom [COS_TABLE_SIZE];

  for (genvar g = 0; g < DAMP_TABLE_SIZE; g++) begin : g_damp_rom
    localparam longint Ang = (acr_pkg::Q30_DAMP_SPAN * g) / (DAMP_TABLE_SIZE - 1);
    localparam logic signed [23:0] Val = acr_pkg::damp_entry(Ang);
    assign damp_rom[g] = Val;
  end

  for (genvar g = 0; g < COS_TABLE_SIZE; g++) begin : g_cos_rom
    localparam longint Ang = (acr_pkg::Q30_PI * g) / (COS_TABLE_SIZE - 1);
    localparam logic signed [23:0] Val = acr_pkg::cos_entry(Ang);
    assign cos_rom[g] = Val;
  end

  function automatic logic signed [23:0] sat24(input logic signed [37:0] v);
    if (v > 38'sd8388607) begin
      return 24'sh7FFFFF;
    end
    if (v < -38'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // clamped loop length and last stage in use
  logic [31:0]   dlen_ext;
  logic [PW:0]   len_eff;
  logic [SW-1:0] nlast;

  always_comb begin
    dlen_ext = 32'(delay_length);
    if (delay_length == '0) begin
      len_eff = (PW + 1)'(1);
    end else if (dlen_ext > 32'(MAX_DELAY)) begin
      len_eff = (PW + 1)'(MAX_DELAY);
    end else begin
      len_eff = (PW + 1)'(dlen_ext);
    end
    if (stages_in_use == '0) begin
      nlast = '0;
    end else if (32'(stages_in_use) > 32'(MAX_STAGES)) begin
      nlast = SW'(MAX_STAGES - 1);
    end else begin
      nlast = SW'(stages_in_use - 5'd1);
    end
  end

  // table position from the registered product freq * scale, 16 fraction bits after >> 8
  logic [31:0]        pos_idx;
  logic [15:0]        pos_frac;
  logic [DAW-1:0]     d_i;
  logic [DAW-1:0]     d_i1;
  logic [CAW-1:0]     c_i;
  logic [CAW-1:0]     c_i1;
  logic signed [23:0] rom_base;
  logic signed [24:0] rom_diff;
  logic [15:0]        rom_frac;

  always_comb begin
    pos_idx  = prod[55:24];
    pos_frac = prod[23:8];
    d_i      = pos_idx[DAW-1:0];
    d_i1     = d_i + 1'b1;
    c_i      = pos_idx[CAW-1:0];
    c_i1     = c_i + 1'b1;
    if (!lk) begin
      if (pos_idx >= 32'(DAMP_TABLE_SIZE - 1)) begin
        // at or past the last entry: the last entry, no slope
        rom_base = damp_rom[DAMP_TABLE_SIZE-1];
        rom_diff = '0;
        rom_frac = '0;
      end else begin
        rom_base = damp_rom[d_i];
        rom_diff = {damp_rom[d_i1][23], damp_rom[d_i1]} - {damp_rom[d_i][23], damp_rom[d_i]};
        rom_frac = pos_frac;
      end
    end else begin
      if (pos_idx >= 32'(COS_TABLE_SIZE - 1)) begin
        rom_base = cos_rom[COS_TABLE_SIZE-1];
        rom_diff = '0;
        rom_frac = '0;
      end else begin
        rom_base = cos_rom[c_i];
        rom_diff = {cos_rom[c_i1][23], cos_rom[c_i1]} - {cos_rom[c_i][23], cos_rom[c_i]};
        rom_frac = pos_frac;
      end
    end
  end

  // multiplier operand selection by step
  logic signed [24:0] one_minus_c;
  logic [31:0]        scale_sel;

  always_comb begin
    one_minus_c = 25'sd4194304 - {c_coef[23], c_coef};
    scale_sel   = lk ? k_index_scale : damp_index_scale;
    mul_a       = '0;
    mul_b       = '0;
    case (state)
      L_MUL: begin
        mul_a = $signed({1'b0, scale_sel});
        mul_b = $signed({1'b0, freq_q});
      end
      L_INT: begin
        mul_a = $signed({17'b0, rom_frac_q});
        mul_b = rom_diff_q;
      end
      S_KMUL: begin
        mul_a = {{8{one_minus_c[24]}}, one_minus_c};
        mul_b = {k_raw[23], k_raw};
      end
      S_FBMUL: begin
        mul_a = {{9{dl_q[23]}}, dl_q};
        mul_b = {{6{feedback_gain[18]}}, feedback_gain};
      end
      ST_A, ST_D: begin
        mul_a = {w1[stg][31], w1[stg]};
        mul_b = {k_coef[23], k_coef};
      end
      ST_B: begin
        mul_a = {w2[stg][31], w2[stg]};
        mul_b = {c_coef[23], c_coef};
      end
      ST_E: begin
        mul_a = {w0r[31], w0r};
        mul_b = {c_coef[23], c_coef};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // delay memory port control
  logic          mem_we;
  logic [PW-1:0] mem_wa;
  logic signed [23:0] mem_wd;
  logic          mem_re;
  logic [PW-1:0] mem_ra;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = pointer;
    mem_wd = left_q;
    mem_re = 1'b0;
    mem_ra = rem[PW-1:0];
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = '0;
      end
      S_WB: begin
        mem_we = 1'b1;
      end
      S_DRD: begin
        mem_re = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      delay_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      dl_q <= delay_mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // accumulator views
  logic signed [ACCW-1:0] prod_ext;
  logic signed [37:0]     acc_sh;
  logic signed [31:0]     stage_y;
  logic signed [23:0]     interp;

  always_comb begin
    prod_ext = {{(ACCW - 58){prod[57]}}, prod};
    acc_sh   = acc[ACCW-1:22];
    stage_y  = sat32(acc_sh);
    // interpolated value, known to fit 24 bits
    interp   = rom_base_q + prod[39:16];
  end

  // sequencer, stage state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLR;
      clr_addr         <= '0;
      clr_item         <= 1'b0;
      out_valid        <= 1'b0;
      pointer          <= '0;
      lk               <= 1'b0;
      stg              <= '0;
      bcnt             <= '0;
      feedback_gain    <= '0;
      damp_index_scale <= 32'd128;
      k_index_scale    <= 32'd377;
      stages_in_use    <= 5'd4;
      delay_length     <= 13'd1;
      for (int i = 0; i < MAX_STAGES; i++) begin
        w1[i] <= '0;
        w2[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          acr_pkg::REG_FEEDBACK_GAIN:    feedback_gain    <= cfg_data[18:0];
          acr_pkg::REG_DAMP_INDEX_SCALE: damp_index_scale <= cfg_data;
          acr_pkg::REG_K_INDEX_SCALE:    k_index_scale    <= cfg_data;
          acr_pkg::REG_STAGES_IN_USE:    stages_in_use    <= cfg_data[4:0];
          acr_pkg::REG_DELAY_LENGTH:     delay_length     <= cfg_data[12:0];
          default: ;
        endcase
      end

      // the output step handles its own handover
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (mode) begin
              // clear word: stage state now, delay memory by sweep
              for (int i = 0; i < MAX_STAGES; i++) begin
                w1[i] <= '0;
                w2[i] <= '0;
              end
              clr_addr <= '0;
              clr_item <= 1'b1;
              state    <= S_CLR;
            end else begin
              audio_q <= audio_in;
              freq_q  <= freq_in;
              lk      <= 1'b0;
              state   <= L_MUL;
            end
          end
        end
        S_CLR: begin
          if (clr_addr == PW'(MAX_DELAY - 1)) begin
            left_q  <= '0;
            right_q <= '0;
            state   <= clr_item ? S_OUT : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        L_MUL: state <= L_ROM;
        L_ROM: begin
          rom_base_q <= rom_base;
          rom_diff_q <= rom_diff;
          rom_frac_q <= rom_frac;
          state      <= L_INT;
        end
        L_INT: state <= L_SUM;
        L_SUM: begin
          if (!lk) begin
            c_coef <= interp;
            lk     <= 1'b1;
            state  <= L_MUL;
          end else begin
            k_raw <= interp;
            state <= S_KMUL;
          end
        end
        S_KMUL: state <= S_KSAT;
        S_KSAT: begin
          // k scaled by (1 - c), then set up pointer + 1 mod length
          k_coef <= sat24({{2{prod[57]}}, prod[57:22]});
          rem    <= {1'b0, pointer} + 1'b1;
          dvs    <= DW'(len_eff) << PW;
          bcnt   <= CW'(PW);
          state  <= S_PMOD;
        end
        S_PMOD: begin
          // restoring remainder, one bit a cycle
          if (DW'(rem) >= dvs) begin
            rem <= rem - (PW + 1)'(dvs);
          end
          dvs <= dvs >> 1;
          if (bcnt == '0) begin
            state <= S_DRD;
          end else begin
            bcnt <= bcnt - 1'b1;
          end
        end
        S_DRD: begin
          pointer <= rem[PW-1:0];
          state   <= S_FBMUL;
        end
        S_FBMUL: state <= S_FBSUM;
        S_FBSUM: begin
          x     <= {{8{audio_q[23]}}, audio_q} + prod[47:16];
          stg   <= '0;
          state <= ST_A;
        end
        ST_A: begin
          // right output taps the input of the last stage
          if (stg == nlast) begin
            right_q <= sat24({{6{x[31]}}, x});
          end
          acc   <= {{(ACCW - 54){x[31]}}, x, 22'b0};
          state <= ST_B;
        end
        ST_B: begin
          acc   <= acc - prod_ext;
          state <= ST_C;
        end
        ST_C: begin
          acc   <= acc + prod_ext;
          state <= ST_D;
        end
        ST_D: begin
          w0r   <= stage_y;
          acc   <= {{(ACCW - 54){w2[stg][31]}}, w2[stg], 22'b0};
          state <= ST_E;
        end
        ST_E: begin
          acc   <= acc + prod_ext;
          state <= ST_F;
        end
        ST_F: begin
          acc   <= acc - prod_ext;
          state <= ST_G;
        end
        ST_G: begin
          w2[stg] <= w1[stg];
          w1[stg] <= w0r;
          x       <= stage_y;
          if (stg == nlast) begin
            left_q <= sat24({{6{stage_y[31]}}, stage_y});
            state  <= S_WB;
          end else begin
            stg   <= stg + 1'b1;
            state <= ST_A;
          end
        end
        S_WB: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_left  <= left_q;
            out_right <= right_q;
            out_valid <= 1'b1;
            clr_item  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic in_stage;
  assign in_stage = (state == ST_A) || (state == ST_B) || (state == ST_C) || (state == ST_D)
                 || (state == ST_E) || (state == ST_F) || (state == ST_G);

  logic clr_take;
  assign clr_take = in_valid && !in_stall && mode;

  `ACR_ASSERT_NOW(a_stage_in_range, in_stage, stg <= nlast, "stage index past last stage in use")
  `ACR_ASSERT_NOW(a_ptr_in_len, state == S_DRD, rem < len_eff, "pointer not below loop length")
  `ACR_ASSERT_NEXT(a_clear_sweeps, clr_take, state == S_CLR && clr_addr == '0, "no clear sweep")
  `ACR_ASSERT_NOW(a_out_from_seq, $rose(out_valid), $past(state == S_OUT), "result word not from output step")

endmodule
